@@ sv/stirl_pkg.sv @@
package stirl_pkg;

  localparam int unsigned N_W = 7;
  localparam int unsigned V_W = 30;

  localparam logic [31:0] MODP   = 32'd1000000007;
  localparam logic [31:0] MODP_2 = 32'd2000000014;

  typedef struct packed {
    logic [N_W-1:0] elements;
    logic [N_W-1:0] groups;
  } in_t;

  typedef struct packed {
    logic [V_W-1:0] first_kind;
    logic [V_W-1:0] second_kind;
  } out_t;

  // broadcast controls from the sequencer to every cell
  typedef struct packed {
    logic load;    // restore row zero
    logic dbl;     // one bit of the serial multiply
    logic fin;     // add left neighbor, commit the new row
    logic shift;   // move the row one cell toward column zero
    logic m1_bit;  // current bit of (i-1), MSB first
  } ctrl_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROW,
    ST_SHIFT,
    ST_FINISH
  } state_t;

  // reduce a value below 3*P into [0, P)
  function automatic logic [V_W-1:0] mod_red(input logic [31:0] t);
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] r;
    t1 = t - MODP;
    t2 = t - MODP_2;
    if (t >= MODP_2) begin
      r = t2;
    end else if (t >= MODP) begin
      r = t1;
    end else begin
      r = t;
    end
    return r[V_W-1:0];
  endfunction

endpackage

@@ sv/stirl_cell.sv @@
module stirl_cell #(
  parameter int IDX = 0,
  parameter int MW  = 1
) (
  input  logic             clk,
  input  stirl_pkg::ctrl_t ctrl_i,
  input  stirl_pkg::out_t  left_i,
  input  stirl_pkg::out_t  right_i,
  output stirl_pkg::out_t  val_o
);

  localparam logic [MW-1:0] IDX_V = MW'(IDX);
  localparam bit            COL0  = (IDX == 0);

  stirl_pkg::out_t                s_r;
  logic [stirl_pkg::V_W-1:0]      a1_r;
  logic [stirl_pkg::V_W-1:0]      a2_r;
  logic [MW-1:0]                  jsh_r;

  logic [31:0]                    d1;
  logic [31:0]                    d2;
  logic [31:0]                    f1;
  logic [31:0]                    f2;

  // double and add for both products, then the neighbor sums
  always_comb begin
    d1 = {1'b0, a1_r, 1'b0} + (ctrl_i.m1_bit ? {2'b0, s_r.first_kind} : 32'd0);
    d2 = {1'b0, a2_r, 1'b0} + (jsh_r[MW-1] ? {2'b0, s_r.second_kind} : 32'd0);
    f1 = {2'b0, left_i.first_kind} + {2'b0, a1_r};
    f2 = {2'b0, left_i.second_kind} + {2'b0, a2_r};
  end

  // hold the column value; advance the serial multiply or the row
  always_ff @(posedge clk) begin
    if (ctrl_i.load) begin
      s_r.first_kind  <= COL0 ? stirl_pkg::V_W'(1) : '0;
      s_r.second_kind <= COL0 ? stirl_pkg::V_W'(1) : '0;
      a1_r            <= '0;
      a2_r            <= '0;
      jsh_r           <= IDX_V;
    end else if (ctrl_i.fin) begin
      s_r.first_kind  <= COL0 ? '0 : stirl_pkg::mod_red(f1);
      s_r.second_kind <= COL0 ? '0 : stirl_pkg::mod_red(f2);
      a1_r            <= '0;
      a2_r            <= '0;
      jsh_r           <= IDX_V;
    end else if (ctrl_i.dbl) begin
      a1_r  <= stirl_pkg::mod_red(d1);
      a2_r  <= stirl_pkg::mod_red(d2);
      jsh_r <= jsh_r << 1;
    end else if (ctrl_i.shift) begin
      s_r <= right_i;
    end
  end

  assign val_o = s_r;

endmodule

@@ sv/stirling_numbers_mod_prime.sv @@
// Answers one query (n, k) at a time with the unsigned Stirling number of the
// first kind s1(n,k) and the Stirling number of the second kind S2(n,k), both
// modulo 1000000007. A row of MAX_N+1 cells holds one column each; every row
// of the recurrence is built across all cells at once, but each cell forms its
// products (i-1)*s1 and j*S2 one multiplier bit per cycle over the MW =
// clog2(MAX_N+1) multiplier bits, then adds its left neighbor. After row n
// the chain shifts k places toward column zero to bring the answer out. A
// query with k > n or n > MAX_N skips the rows and returns zeros. The next
// query is taken once the result is in the output register, even while that
// beat is still stalled.
module stirling_numbers_mod_prime #(
  parameter int MAX_N = 64
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  stirl_pkg::in_t  in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output stirl_pkg::out_t out_data
);

  localparam int NC = MAX_N + 1;
  localparam int MW = $clog2(MAX_N + 1);
  localparam int PW = $clog2(MW + 1);

  stirl_pkg::state_t              state_r, state_nxt;
  logic [stirl_pkg::N_W-1:0]      n_r, n_nxt;
  logic [stirl_pkg::N_W-1:0]      k_r, k_nxt;
  logic [stirl_pkg::N_W-1:0]      row_r, row_nxt;
  logic [stirl_pkg::N_W-1:0]      sh_r, sh_nxt;
  logic [PW-1:0]                  ph_r, ph_nxt;
  logic [MW-1:0]                  im1_r, im1_nxt;
  logic                           zero_r, zero_nxt;
  logic                           out_valid_r, out_valid_nxt;
  stirl_pkg::out_t                out_data_r, out_data_nxt;
  stirl_pkg::ctrl_t               ctrl;
  logic                           in_acc;
  logic                           bad_q;

  stirl_pkg::out_t                cval [NC];

  // chain of column cells
  for (genvar j = 0; j < NC; j++) begin : g_cell
    stirl_pkg::out_t lft;
    stirl_pkg::out_t rgt;
    if (j == 0) begin : g_l0
      assign lft = '0;
    end else begin : g_ln
      assign lft = cval[j-1];
    end
    if (j == NC - 1) begin : g_rl
      assign rgt = '0;
    end else begin : g_rn
      assign rgt = cval[j+1];
    end
    stirl_cell #(.IDX(j), .MW(MW)) u_cell (
      .clk    (clk),
      .ctrl_i (ctrl),
      .left_i (lft),
      .right_i(rgt),
      .val_o  (cval[j])
    );
  end

  assign in_stall = (state_r != stirl_pkg::ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign bad_q    = (32'(in_data.elements) > 32'(MAX_N)) ||
                    (in_data.groups > in_data.elements);

  // sequencer: next state and cell controls
  always_comb begin
    state_nxt     = state_r;
    n_nxt         = n_r;
    k_nxt         = k_r;
    row_nxt       = row_r;
    sh_nxt        = sh_r;
    ph_nxt        = ph_r;
    im1_nxt       = im1_r;
    zero_nxt      = zero_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctrl          = '0;
    ctrl.m1_bit   = im1_r[MW-1];
    unique case (state_r)
      stirl_pkg::ST_IDLE: begin
        if (in_acc) begin
          ctrl.load = 1'b1;
          n_nxt     = in_data.elements;
          k_nxt     = in_data.groups;
          row_nxt   = stirl_pkg::N_W'(1);
          ph_nxt    = '0;
          im1_nxt   = '0;
          sh_nxt    = in_data.groups;
          zero_nxt  = bad_q;
          if (bad_q) begin
            state_nxt = stirl_pkg::ST_FINISH;
          end else if (in_data.elements == '0) begin
            state_nxt = stirl_pkg::ST_SHIFT;
          end else begin
            state_nxt = stirl_pkg::ST_ROW;
          end
        end
      end
      stirl_pkg::ST_ROW: begin
        if (ph_r != PW'(MW)) begin
          ctrl.dbl = 1'b1;
          ph_nxt   = ph_r + PW'(1);
          im1_nxt  = im1_r << 1;
        end else begin
          ctrl.fin = 1'b1;
          ph_nxt   = '0;
          if (row_r == n_r) begin
            sh_nxt    = k_r;
            state_nxt = stirl_pkg::ST_SHIFT;
          end else begin
            row_nxt = row_r + stirl_pkg::N_W'(1);
            im1_nxt = MW'(row_r);
          end
        end
      end
      stirl_pkg::ST_SHIFT: begin
        if (sh_r == '0) begin
          state_nxt = stirl_pkg::ST_FINISH;
        end else begin
          ctrl.shift = 1'b1;
          sh_nxt     = sh_r - stirl_pkg::N_W'(1);
        end
      end
      stirl_pkg::ST_FINISH: begin
        if (!out_valid_r || !out_stall) begin
          out_data_nxt  = zero_r ? '0 : cval[0];
          out_valid_nxt = 1'b1;
          state_nxt     = stirl_pkg::ST_IDLE;
        end
      end
      default: state_nxt = stirl_pkg::ST_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= stirl_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // query and counter payload
  always_ff @(posedge clk) begin
    n_r        <= n_nxt;
    k_r        <= k_nxt;
    row_r      <= row_nxt;
    sh_r       <= sh_nxt;
    ph_r       <= ph_nxt;
    im1_r      <= im1_nxt;
    zero_r     <= zero_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // checks
  a_ctrl_one: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({ctrl.load, ctrl.dbl, ctrl.fin, ctrl.shift}))
    else $error("more than one cell command at once");

  a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == stirl_pkg::ST_ROW) |->
      (row_r != '0) && (row_r <= n_r) && (ph_r <= PW'(MW)))
    else $error("row or phase counter out of range");

  a_bad_fast: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && bad_q) |=> (state_r == stirl_pkg::ST_FINISH) && zero_r)
    else $error("empty query did not go straight to finish");

  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == stirl_pkg::ST_FINISH))
    else $error("result beat raised outside finish");

endmodule
